// ----- hw/rtl/dkb_pkg.sv -----
`default_nettype none

package dkb_pkg;

    // Width of every color and opacity field.
    localparam int DATA_W = 16;

    // Configuration port geometry: two 32-bit registers at byte offsets 0 and 4.
    localparam int ADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from the word address bit.
    localparam logic REG_ALPHA_MODE    = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    // Load enables for the pipeline stages behind the input register.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

`default_nettype wire

// ----- hw/rtl/dkb_chan.sv -----
`default_nettype none

// One color channel of the blend, pipeline stages two to four.
// Stage two forms the products, stage three rounds them, stage four
// takes the minimum, sums, saturates and applies the channel-in-use mask; with alpha mode off it passes min(fg, bg).
module dkb_chan #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                          i_clk,
    input  wire dkb_pkg::t_stage_en            i_en,
    input  wire logic                          i_alpha_mode,
    input  wire logic                          i_used,
    input  wire logic [dkb_pkg::DATA_W-1:0]    i_fg,
    input  wire logic [dkb_pkg::DATA_W-1:0]    i_bg,
    input  wire logic [dkb_pkg::DATA_W-1:0]    i_fa,
    input  wire logic [dkb_pkg::DATA_W-1:0]    i_ba,
    output logic      [dkb_pkg::DATA_W-1:0]    o_color
);

    localparam int DW    = dkb_pkg::DATA_W;
    localparam int ONE_W = FRAC_BITS + 1;
    localparam int CW    = (ONE_W > DW) ? ONE_W : DW;
    localparam int PW    = DW + CW;
    localparam int RW    = PW + 1 - FRAC_BITS;
    localparam int SW    = RW + 2;
    localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
    localparam logic [PW:0]   HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam int LIM_I = (FRAC_BITS >= 16) ? 65535 : (1 << FRAC_BITS);
    localparam logic [DW-1:0] LIM  = DW'(LIM_I);

    // Round to nearest, half up, and drop the fraction bits.
    function automatic logic [RW-1:0] round_prod(input logic [PW-1:0] x);
        logic [PW:0] s;
        s = {1'b0, x} + HALF;
        return s[PW:FRAC_BITS];
    endfunction

    logic [CW-1:0] w_one_m_ba;
    logic [CW-1:0] w_one_m_fa;
    logic [PW-1:0] w_p;
    logic [PW-1:0] w_q;
    logic [PW-1:0] w_u;
    logic [PW-1:0] w_v;

    logic [PW-1:0] r_s2_p;
    logic [PW-1:0] r_s2_q;
    logic [PW-1:0] r_s2_u;
    logic [PW-1:0] r_s2_v;
    logic [DW-1:0] r_s2_min;

    logic [RW-1:0] r_s3_p;
    logic [RW-1:0] r_s3_q;
    logic [RW-1:0] r_s3_u;
    logic [RW-1:0] r_s3_v;
    logic [DW-1:0] r_s3_min;

    logic [RW-1:0] w_pq_min;
    logic [SW-1:0] w_total;
    logic [DW-1:0] n_color;
    logic [DW-1:0] r_color;

    // Products of stage two.
    assign w_one_m_ba = ONE - CW'(i_ba);
    assign w_one_m_fa = ONE - CW'(i_fa);
    assign w_p = PW'(i_fg) * PW'(i_ba);
    assign w_q = PW'(i_bg) * PW'(i_fa);
    assign w_u = PW'(i_fg) * PW'(w_one_m_ba);
    assign w_v = PW'(i_bg) * PW'(w_one_m_fa);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_p   <= w_p;
            r_s2_q   <= w_q;
            r_s2_u   <= w_u;
            r_s2_v   <= w_v;
            r_s2_min <= (i_fg < i_bg) ? i_fg : i_bg;
        end
    end

    // Rounding of stage three.
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_p   <= round_prod(r_s2_p);
            r_s3_q   <= round_prod(r_s2_q);
            r_s3_u   <= round_prod(r_s2_u);
            r_s3_v   <= round_prod(r_s2_v);
            r_s3_min <= r_s2_min;
        end
    end

    // Sum and saturation of stage four.
    assign w_pq_min = (r_s3_p < r_s3_q) ? r_s3_p : r_s3_q;
    assign w_total  = SW'(w_pq_min) + SW'(r_s3_u) + SW'(r_s3_v);

    always_comb begin
        if (!i_used) begin
            n_color = '0;
        end else if (!i_alpha_mode) begin
            n_color = r_s3_min;
        end else if (w_total > SW'(LIM)) begin
            n_color = LIM;
        end else begin
            n_color = w_total[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_color <= n_color;
        end
    end

    assign o_color = r_color;

endmodule

`default_nettype wire

// ----- hw/rtl/darken_blend_pixel_top.sv -----
`default_nettype none

// Darken blend of a foreground and a background pixel, one pixel per transfer.
// Pipeline: four register stages (clamp, multiply, round, sum and saturate); output
// valid travels through the valid registers r_v1 to r_v4 alongside the data.
// Throughput: one pixel per cycle unless stalled; a stall only closes up bubbles.
// Reset (synchronous, active low) empties the pipeline and sets alpha_mode to 0
// and channel_count to 3.
module darken_blend_pixel_top #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dkb_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [dkb_pkg::PDATA_W-1:0]     pwdata,
    output logic      [dkb_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_fg_color0,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_fg_color1,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_fg_color2,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_fg_opacity,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_bg_color0,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_bg_color1,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_bg_color2,
    input  wire logic [dkb_pkg::DATA_W-1:0]      i_bg_opacity,
    input  wire logic                            i_line_end,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [dkb_pkg::DATA_W-1:0]      o_out_color0,
    output logic      [dkb_pkg::DATA_W-1:0]      o_out_color1,
    output logic      [dkb_pkg::DATA_W-1:0]      o_out_color2,
    output logic      [dkb_pkg::DATA_W-1:0]      o_out_opacity,
    output logic                                 o_line_end_out
);

    localparam int DW    = dkb_pkg::DATA_W;
    localparam int NCH   = 3;
    localparam int LIM_I = (FRAC_BITS >= 16) ? 65535 : (1 << FRAC_BITS);
    localparam logic [DW-1:0] LIM = DW'(LIM_I);
    localparam int MPW   = 2 * DW;
    localparam int MRW   = MPW + 1 - FRAC_BITS;
    localparam int SUMW  = DW + 1;
    localparam int AW    = (MRW > SUMW) ? MRW : SUMW;
    localparam logic [MPW:0] HALF = (MPW + 1)'(1) << (FRAC_BITS - 1);

    function automatic logic [DW-1:0] clamp_in(input logic [DW-1:0] v);
        return (v > LIM) ? LIM : v;
    endfunction

    // Configuration registers.
    logic       r_alpha_mode;
    logic [1:0] r_channel_count;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode    <= 1'b0;
            r_channel_count <= 2'd3;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                dkb_pkg::REG_ALPHA_MODE:    r_alpha_mode    <= pwdata[0];
                dkb_pkg::REG_CHANNEL_COUNT: r_channel_count <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dkb_pkg::REG_ALPHA_MODE:    prdata = {31'd0, r_alpha_mode};
            dkb_pkg::REG_CHANNEL_COUNT: prdata = {30'd0, r_channel_count};
            default:                    prdata = '0;
        endcase
    end

    // Stage advance: a stage loads when it is empty or the next one moves.
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic               w_en1;
    dkb_pkg::t_stage_en w_en;

    assign w_en.s4    = !r_v4 || !i_out_stall;
    assign w_en.s3    = !r_v3 || w_en.s4;
    assign w_en.s2    = !r_v2 || w_en.s3;
    assign w_en1      = !r_v1 || w_en.s2;
    assign o_in_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1)   r_v1 <= i_in_valid;
            if (w_en.s2) r_v2 <= r_v1;
            if (w_en.s3) r_v3 <= r_v2;
            if (w_en.s4) r_v4 <= r_v3;
        end
    end

    // Stage one: clamp every input value to the saturation limit.
    logic [DW-1:0] r_s1_fg [NCH];
    logic [DW-1:0] r_s1_bg [NCH];
    logic [DW-1:0] r_s1_fa;
    logic [DW-1:0] r_s1_ba;
    logic          r_s1_le;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_fg[0] <= clamp_in(i_fg_color0);
            r_s1_fg[1] <= clamp_in(i_fg_color1);
            r_s1_fg[2] <= clamp_in(i_fg_color2);
            r_s1_bg[0] <= clamp_in(i_bg_color0);
            r_s1_bg[1] <= clamp_in(i_bg_color1);
            r_s1_bg[2] <= clamp_in(i_bg_color2);
            r_s1_fa    <= clamp_in(i_fg_opacity);
            r_s1_ba    <= clamp_in(i_bg_opacity);
            r_s1_le    <= i_line_end;
        end
    end

    // Channel count zero behaves as one channel; channel 0 is always in use; configuration is read live.
    // The user must let the configuration stay put while pixels are in flight; the block does not enforce this.
    logic          w_used [NCH];
    logic [DW-1:0] w_color [NCH];

    assign w_used[0] = 1'b1;
    assign w_used[1] = r_channel_count inside {2'd2, 2'd3};
    assign w_used[2] = (r_channel_count == 2'd3);

    for (genvar g = 0; g < NCH; g++) begin : g_chan
        dkb_chan #(
            .FRAC_BITS (FRAC_BITS)
        ) u_chan (
            .i_clk        (i_clk),
            .i_en         (w_en),
            .i_alpha_mode (r_alpha_mode),
            .i_used       (w_used[g]),
            .i_fg         (r_s1_fg[g]),
            .i_bg         (r_s1_bg[g]),
            .i_fa         (r_s1_fa),
            .i_ba         (r_s1_ba),
            .o_color      (w_color[g])
        );
    end

    // Result opacity: fa + ba - round(fa * ba), saturated, or zero with alpha mode off; same stage split as the colors.
    logic [SUMW-1:0] r_s2_sum;
    logic [MPW-1:0]  r_s2_mprod;
    logic            r_s2_le;
    logic [SUMW-1:0] r_s3_sum;
    logic [MRW-1:0]  r_s3_m;
    logic            r_s3_le;
    logic [MPW:0]    w_mround;
    logic [AW-1:0]   w_ca;
    logic [DW-1:0]   n_opacity;
    logic [DW-1:0]   r_s4_opacity;
    logic            r_s4_le;

    always_ff @(posedge i_clk) begin
        if (w_en.s2) begin
            r_s2_sum   <= SUMW'(r_s1_fa) + SUMW'(r_s1_ba);
            r_s2_mprod <= MPW'(r_s1_fa) * MPW'(r_s1_ba);
            r_s2_le    <= r_s1_le;
        end
    end

    assign w_mround = {1'b0, r_s2_mprod} + HALF;

    always_ff @(posedge i_clk) begin
        if (w_en.s3) begin
            r_s3_sum <= r_s2_sum;
            r_s3_m   <= w_mround[MPW:FRAC_BITS];
            r_s3_le  <= r_s2_le;
        end
    end

    assign w_ca = (AW'(r_s3_sum) > AW'(r_s3_m)) ? (AW'(r_s3_sum) - AW'(r_s3_m)) : '0;

    always_comb begin
        if (!r_alpha_mode) begin
            n_opacity = '0;
        end else if (w_ca > AW'(LIM)) begin
            n_opacity = LIM;
        end else begin
            n_opacity = w_ca[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en.s4) begin
            r_s4_opacity <= n_opacity;
            r_s4_le      <= r_s3_le;
        end
    end

    // Output register is the last stage.
    assign o_out_valid    = r_v4;
    assign o_out_color0   = w_color[0];
    assign o_out_color1   = w_color[1];
    assign o_out_color2   = w_color[2];
    assign o_out_opacity  = r_s4_opacity;
    assign o_line_end_out = r_s4_le;

endmodule

`default_nettype wire

// ----- hw/rtl/dkb_chk.sv -----
`default_nettype none

// Port-level checks of the blend pipeline.
module dkb_chk #(
    parameter int FRAC_BITS = 15
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [dkb_pkg::DATA_W-1:0]   o_out_color0,
    input wire logic [dkb_pkg::DATA_W-1:0]   o_out_opacity
);

    localparam int DW    = dkb_pkg::DATA_W;
    localparam int LIM_I = (FRAC_BITS >= 16) ? 65535 : (1 << FRAC_BITS);
    localparam logic [DW-1:0] LIM = DW'(LIM_I);

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid && !o_in_stall;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_color0) && $stable(o_out_opacity))
        else $error("output payload changed under stall");

    // With the output free to move, a transferred pixel passes stages one to four and then appears at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid)
        else $error("pixel did not reach the output in four cycles");

    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The channel 0 color and the opacity never exceed the saturation limit.
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_color0 <= LIM) && (o_out_opacity <= LIM))
        else $error("result above saturation limit");

endmodule

bind darken_blend_pixel_top dkb_chk #(
    .FRAC_BITS (FRAC_BITS)
) u_dkb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_color0  (o_out_color0),
    .o_out_opacity (o_out_opacity)
);

`default_nettype wire
